@@ hdl/binomial_mod_prime_defines.svh @@
// assertion macros for the binomial mod prime checker
`ifndef BINOMIAL_MOD_PRIME_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BMP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bmp_pkg.sv @@
// shared types and constants for the binomial coefficient modulo prime block
package bmp_pkg;

   localparam int N_BITS = 16;
   localparam int RES_W  = 30;
   localparam int IDX_W  = $clog2(RES_W);

   typedef logic [N_BITS-1:0] arg_type;
   typedef logic [N_BITS:0]   cnt_type;
   typedef logic [RES_W-1:0]  residue_type;
   typedef logic [IDX_W-1:0]  bit_idx_type;

   localparam residue_type PRIME_VAL = RES_W'(1000000007);
   localparam residue_type EXP_VAL   = RES_W'(1000000005);
   localparam logic [31:0] PRIME32   = 32'd1000000007;
   localparam logic [31:0] TWO_P32   = 32'd2000000014;
   localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'd1000000007);

   typedef struct packed {
      logic [15:0] n_value;
      logic [15:0] k_value;
   } req_type;

   typedef struct packed {
      logic [29:0] binomial;
      logic        bad_args;
   } rsp_type;

endpackage

@@ hdl/bmp_mulmod.sv @@
// modular multiplier over one shared 31x31 multiplier with barrett reduction
module bmp_mulmod import bmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  residue_type op_a,
   input  residue_type op_b,
   output logic        done,
   output residue_type prod
);

   typedef enum logic [2:0] {M_IDLE, M_MUL, M_QEST, M_QP, M_CORR} mstate_type;

   mstate_type  state_ff, state_in;
   logic        done_ff, done_in;
   residue_type a_ff, a_in;
   residue_type b_ff, b_in;
   logic [59:0] x_ff, x_in;
   logic [30:0] q_ff, q_in;
   logic [31:0] qp_ff, qp_in;
   residue_type prod_ff, prod_in;

   logic [30:0] mul_a;
   logic [30:0] mul_b;
   logic [61:0] mul_p;
   logic [31:0] rem;

   assign mul_p = mul_a * mul_b;
   assign rem   = x_ff[31:0] - qp_ff;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      qp_in    = qp_ff;
      prod_in  = prod_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         M_IDLE: begin
            if (go) begin
               a_in     = op_a;
               b_in     = op_b;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            mul_a    = {1'b0, a_ff};
            mul_b    = {1'b0, b_ff};
            x_in     = mul_p[59:0];
            state_in = M_QEST;
         end
         M_QEST: begin
            mul_a    = x_ff[59:29];
            mul_b    = BARRETT_M;
            q_in     = mul_p[61:31];
            state_in = M_QP;
         end
         M_QP: begin
            mul_a    = q_ff;
            mul_b    = {1'b0, PRIME_VAL};
            qp_in    = mul_p[31:0];
            state_in = M_CORR;
         end
         M_CORR: begin
            if (rem >= TWO_P32) begin
               prod_in = residue_type'(rem - TWO_P32);
            end else if (rem >= PRIME32) begin
               prod_in = residue_type'(rem - PRIME32);
            end else begin
               prod_in = residue_type'(rem);
            end
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      q_ff    <= q_in;
      qp_ff   <= qp_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

@@ hdl/binomial_mod_prime.sv @@
// binomial coefficient C(n,k) modulo 1000000007, top level
//
// Request channel: drive req_data (n_value, k_value) and raise start; the
// request is taken at a clock edge where start is high and busy is low.
// Only the low N_BITS bits of each argument are used.
// Result channel: rsp_data (binomial, bad_args) is shown for exactly one
// cycle while rsp_strobe is high; the receiver cannot stall it.
// k greater than n: the result {0, bad_args=1} appears the next cycle and
// busy stays low. Otherwise busy rises for the whole computation.
// Every step is a modular multiplication in one shared multiply-reduce
// unit: n-1 steps build the factorials (none for n below 2), one forms
// k!(n-k)!, 45 raise it to p-2 for the inverse and one applies it, and
// one request is in work at a time. busy falls in the cycle the result
// is strobed.
// Reset (synchronous, active high) abandons any request in work and
// returns the block to idle with no result pending.
module binomial_mod_prime import bmp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {S_IDLE, S_FACT, S_PAIR, S_SQR, S_MULT, S_FINAL} state_type;

   state_type   state_ff, state_in;
   logic        pend_ff, pend_in;
   logic        strobe_ff, strobe_in;
   rsp_type     rsp_ff, rsp_in;
   arg_type     n_ff, n_in;
   arg_type     k_ff, k_in;
   arg_type     nk_ff, nk_in;
   cnt_type     i_ff, i_in;
   residue_type f_ff, f_in;
   residue_type fk_ff, fk_in;
   residue_type fnk_ff, fnk_in;
   residue_type g_ff, g_in;
   residue_type r_ff, r_in;
   bit_idx_type j_ff, j_in;

   logic        mul_go;
   residue_type mul_a;
   residue_type mul_b;
   logic        mul_done;
   residue_type mul_prod;
   arg_type     n_req;
   arg_type     k_req;

   bmp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign n_req = arg_type'(req_data.n_value);
   assign k_req = arg_type'(req_data.k_value);

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      nk_in     = nk_ff;
      i_in      = i_ff;
      f_in      = f_ff;
      fk_in     = fk_ff;
      fnk_in    = fnk_ff;
      g_in      = g_ff;
      r_in      = r_ff;
      j_in      = j_ff;
      mul_go    = 1'b0;
      mul_a     = f_ff;
      mul_b     = r_ff;
      unique case (state_ff)
         S_IDLE: begin
            pend_in = 1'b0;
            if (start) begin
               if (k_req > n_req) begin
                  strobe_in       = 1'b1;
                  rsp_in.binomial = '0;
                  rsp_in.bad_args = 1'b1;
               end else begin
                  n_in     = n_req;
                  k_in     = k_req;
                  nk_in    = n_req - k_req;
                  i_in     = cnt_type'(2);
                  f_in     = residue_type'(1);
                  fk_in    = residue_type'(1);
                  fnk_in   = residue_type'(1);
                  state_in = S_FACT;
               end
            end
         end
         S_FACT: begin
            mul_a = f_ff;
            mul_b = residue_type'(i_ff);
            if (!pend_ff) begin
               if (i_ff > {1'b0, n_ff}) begin
                  state_in = S_PAIR;
               end else begin
                  mul_go  = 1'b1;
                  pend_in = 1'b1;
               end
            end else if (mul_done) begin
               pend_in = 1'b0;
               f_in    = mul_prod;
               if (i_ff == {1'b0, k_ff}) begin
                  fk_in = mul_prod;
               end
               if (i_ff == {1'b0, nk_ff}) begin
                  fnk_in = mul_prod;
               end
               i_in = i_ff + cnt_type'(1);
            end
         end
         S_PAIR: begin
            mul_a = fk_ff;
            mul_b = fnk_ff;
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mul_done) begin
               pend_in  = 1'b0;
               g_in     = mul_prod;
               r_in     = residue_type'(1);
               j_in     = bit_idx_type'(RES_W - 1);
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            mul_a = r_ff;
            mul_b = r_ff;
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mul_done) begin
               pend_in = 1'b0;
               r_in    = mul_prod;
               if (EXP_VAL[j_ff]) begin
                  state_in = S_MULT;
               end else if (j_ff == '0) begin
                  state_in = S_FINAL;
               end else begin
                  j_in = j_ff - bit_idx_type'(1);
               end
            end
         end
         S_MULT: begin
            mul_a = r_ff;
            mul_b = g_ff;
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mul_done) begin
               pend_in = 1'b0;
               r_in    = mul_prod;
               if (j_ff == '0) begin
                  state_in = S_FINAL;
               end else begin
                  j_in     = j_ff - bit_idx_type'(1);
                  state_in = S_SQR;
               end
            end
         end
         S_FINAL: begin
            mul_a = f_ff;
            mul_b = r_ff;
            if (!pend_ff) begin
               mul_go  = 1'b1;
               pend_in = 1'b1;
            end else if (mul_done) begin
               pend_in         = 1'b0;
               strobe_in       = 1'b1;
               rsp_in.binomial = mul_prod;
               rsp_in.bad_args = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
      n_ff   <= n_in;
      k_ff   <= k_in;
      nk_ff  <= nk_in;
      i_ff   <= i_in;
      f_ff   <= f_in;
      fk_ff  <= fk_in;
      fnk_ff <= fnk_in;
      g_ff   <= g_in;
      r_ff   <= r_in;
      j_ff   <= j_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ hdl/bmp_checker.sv @@
// port-level checker for the binomial mod prime block, with its bind
`include "binomial_mod_prime_defines.svh"

module bmp_checker import bmp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   `BMP_ASSERT_NEXT(a_accept_answers, start && !busy, busy || rsp_strobe, "request neither worked on nor answered")
   `BMP_ASSERT_SAME(a_done_strobes, $fell(busy) && !$past(reset), rsp_strobe, "busy fell without a result")
   `BMP_ASSERT_SAME(a_strobe_idle, rsp_strobe, !busy, "result strobed while still busy")
   `BMP_ASSERT_SAME(a_bad_is_zero, rsp_strobe && rsp_data.bad_args, rsp_data.binomial == '0, "bad arguments with nonzero result")

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (.*);

@@ dv/binomial_mod_prime_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the binomial coefficient modulo prime block
module binomial_mod_prime_tb;
   import bmp_pkg::*;

   localparam longint unsigned MODULUS = 64'd1000000007;
   localparam longint CYCLE_LIMIT = 6_000_000;
   localparam int DRAIN_CYCLES = 2500;
   localparam int MAX_REPORTS = 10;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   longint unsigned factorial_mod [0:(1 << N_BITS) - 1];
   rsp_type pending_coeffs [$];
   req_type pending_args [$];
   int idle_pct = 0;
   int requests_sent = 0;
   int bad_arg_requests = 0;
   int results_seen = 0;
   int mismatches = 0;
   int unsigned largest_n = 0;
   longint cycle_count = 0;

   binomial_mod_prime dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("binomial_mod_prime test failed");
      $finish;
   end

   function automatic longint unsigned pow_mod(longint unsigned base,
                                                longint unsigned power);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1;
      sq = base % MODULUS;
      while (power != 0) begin
         if ((power & 1) != 0) acc = (acc * sq) % MODULUS;
         sq = (sq * sq) % MODULUS;
         power = power >> 1;
      end
      return acc;
   endfunction

   // only the low N_BITS of each argument count
   function automatic rsp_type binomial_of(req_type r);
      arg_type n;
      arg_type k;
      longint unsigned coeff;
      rsp_type res;
      n = arg_type'(r.n_value);
      k = arg_type'(r.k_value);
      res = '0;
      if (k > n) begin
         res.bad_args = 1'b1;
      end else begin
         coeff = (factorial_mod[n] * pow_mod(factorial_mod[k], MODULUS - 2)) % MODULUS;
         coeff = (coeff * pow_mod(factorial_mod[n - k], MODULUS - 2)) % MODULUS;
         res.binomial = coeff[29:0];
      end
      return res;
   endfunction

   task automatic issue_request(input logic [15:0] n, input logic [15:0] k);
      req_type r;
      r.n_value = n;
      r.k_value = k;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_coeffs = {pending_coeffs, binomial_of(r)};
      pending_args = {pending_args, r};
      requests_sent++;
      if (k > n) bad_arg_requests++;
      else if (32'(n) > largest_n) largest_n = 32'(n);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      req_type args;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_coeffs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: binomial %0d bad_args %0b",
                        rsp_data.binomial, rsp_data.bad_args);
         end else begin
            want = pending_coeffs.pop_front();
            args = pending_args.pop_front();
            if (rsp_data.binomial !== want.binomial ||
                rsp_data.bad_args !== want.bad_args) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch n=%0d k=%0d: expected %0d/%0b, got %0d/%0b",
                           args.n_value, args.k_value, want.binomial, want.bad_args,
                           rsp_data.binomial, rsp_data.bad_args);
            end
         end
      end
   end

   task automatic test_small_cases();
      issue_request(16'd0, 16'd0);
      issue_request(16'd1, 16'd0);
      issue_request(16'd1, 16'd1);
      issue_request(16'd2, 16'd0);
      issue_request(16'd2, 16'd1);
      issue_request(16'd2, 16'd2);
      issue_request(16'd3, 16'd1);
      issue_request(16'd5, 16'd2);
      issue_request(16'd10, 16'd5);
      issue_request(16'd20, 16'd10);
      issue_request(16'd13, 16'd13);
      issue_request(16'd12, 16'd0);
      issue_request(16'd47, 16'd23);
      issue_request(16'd100, 16'd50);
      issue_request(16'd200, 16'd1);
      issue_request(16'd255, 16'd128);
   endtask

   // k above n, answered at once with the error flag
   task automatic test_bad_args();
      issue_request(16'd0, 16'd1);
      issue_request(16'd0, 16'hFFFF);
      issue_request(16'd1, 16'd2);
      issue_request(16'd5, 16'd6);
      issue_request(16'hFFFE, 16'hFFFF);
      issue_request(16'h7FFF, 16'h8000);
      issue_request(16'h5555, 16'hAAAA);
   endtask

   task automatic test_largest_n();
      issue_request(16'hFFFF, 16'($urandom_range(65535)));
   endtask

   // mostly short factorial chains, some longer ones, some invalid pairs
   task automatic test_random(input int count);
      int unsigned n;
      int unsigned k;
      int unsigned sel;
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            n = $urandom_range(300);
            case ($urandom_range(3))
               0: k = 0;
               1: k = n;
               default: k = $urandom_range(n);
            endcase
         end else if (sel < 80) begin
            n = $urandom_range(2500);
            k = $urandom_range(n);
         end else begin
            n = $urandom_range(65534);
            k = $urandom_range(65535, n + 1);
         end
         issue_request(16'(n), 16'(k));
      end
   endtask

   initial begin : run_tests
      factorial_mod[0] = 1;
      for (int i = 1; i < (1 << N_BITS); i++)
         factorial_mod[i] = (factorial_mod[i - 1] * longint'(i)) % MODULUS;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      test_small_cases();
      test_bad_args();
      test_largest_n();
      idle_pct = 0;
      test_random(25);
      idle_pct = 76;
      test_random(25);
      idle_pct = 26;
      test_random(27);
      start <= 1'b0;

      while (pending_coeffs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_coeffs.size() != 0) mismatches += pending_coeffs.size();

      $display("%0d requests (%0d with k above n), %0d results checked, %0d mismatches",
               requests_sent, bad_arg_requests, results_seen, mismatches);
      $display("largest valid n %0d, sender gaps at 0/76/26 percent", largest_n);
      if (mismatches == 0) begin
         $display("binomial_mod_prime test passed");
      end else begin
         $display("binomial_mod_prime test failed");
      end
      $finish;
   end

endmodule
